@@ hw/rtl/lamc_pkg.sv @@
`default_nettype none
package lamc_pkg;

  localparam int POS_BITS  = 20;
  localparam int MM_BITS   = 13;
  localparam int EDGE_BITS = 4;
  localparam int PPM_BITS  = 16;
  localparam int WIN_BITS  = 10;
  localparam int OP_BITS   = 2;
  localparam int EV_BITS   = 3;
  localparam int CFG_BITS  = 20;
  localparam int CFG_IDX_BITS = 2;
  // Q8.8 product, integer part, then shifted left by two bits into encoder edge units
  localparam int PROD_BITS = PPM_BITS + MM_BITS;
  localparam int RAW_BITS  = PROD_BITS - 8 + 2;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [WIN_BITS-1:0] win_t;

  localparam logic [OP_BITS-1:0] OP_TICK = 2'd0;
  localparam logic [OP_BITS-1:0] OP_MOVE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_HOME = 2'd2;

  localparam logic [EV_BITS-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_BITS-1:0] EV_REACHED = 3'd1;
  localparam logic [EV_BITS-1:0] EV_STALLED = 3'd2;
  localparam logic [EV_BITS-1:0] EV_HOMED   = 3'd3;
  localparam logic [EV_BITS-1:0] EV_BUSY    = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PPM        = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRAVEL     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STALL_WIN  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_WIN   = 2'd3;

  localparam logic [PPM_BITS-1:0] PPM_RESET       = 16'd5709;
  localparam logic [19:0]         TRAVEL_RESET    = 20'd150328;
  localparam logic [WIN_BITS-1:0] STALL_WIN_RESET = 10'd100;
  localparam logic [WIN_BITS-1:0] HOME_WIN_RESET  = 10'd500;

  localparam logic DIR_OUTWARD = 1'b0;
  localparam logic DIR_RETRACT = 1'b1;

  typedef struct packed {
    logic [PPM_BITS-1:0] ppm_q8;
    logic [19:0]         travel_limit;
    win_t                stall_win;
    win_t                home_win;
  } cfg_t;

  typedef struct packed {
    logic dir;
    pos_t target;
  } cmd_t;

  typedef struct packed {
    logic               running;
    logic               direction;
    logic [19:0]        position;
    logic [EV_BITS-1:0] event_res;
  } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/lamc_in_if.sv @@
`default_nettype none
interface lamc_in_if;
  logic                              valid;
  logic                              ready;
  logic [lamc_pkg::OP_BITS-1:0]      operation;
  logic signed [lamc_pkg::MM_BITS-1:0] move_mm;
  logic [lamc_pkg::EDGE_BITS-1:0]    encoder_edges;

  modport source (output valid, operation, move_mm, encoder_edges, input ready);
  modport sink (input valid, operation, move_mm, encoder_edges, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lamc_out_if.sv @@
`default_nettype none
interface lamc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           running;
  logic                           direction;
  logic [19:0]                    position;
  logic [lamc_pkg::EV_BITS-1:0]   event_res;

  modport source (output valid, running, direction, position, event_res, input ready);
  modport sink (input valid, running, direction, position, event_res, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/linear_actuator_move_controller.sv @@
`default_nettype none
// Stages: the input register holds an accepted transaction until the result register
// can take it, and the sink takes its result from the result register.
// Throughput: one transaction per cycle while the sink keeps ready high; while a result
// waits, the input register takes one more transaction and then holds ready low.
// Reset: rst_n is synchronous, active low; it clears the motion state, empties
// both stages and loads the register defaults.
module linear_actuator_move_controller (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  lamc_in_if.sink                                  in_ch,
  lamc_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [lamc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [lamc_pkg::CFG_BITS-1:0]       cfg_wdata
);

  lamc_pkg::cfg_t cfg;
  lamc_pkg::res_t res;

  logic                                in_valid_r;
  logic [lamc_pkg::OP_BITS-1:0]        in_op_r;
  logic signed [lamc_pkg::MM_BITS-1:0] in_mm_r;
  logic [lamc_pkg::EDGE_BITS-1:0]      in_edges_r;
  logic                                out_valid_r;
  logic                                advance;
  logic                                step;
  logic                                in_take;

  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (step) begin
        in_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the payload until the core takes it
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r    <= in_ch.operation;
      in_mm_r    <= in_ch.move_mm;
      in_edges_r <= in_ch.encoder_edges;
    end
  end

  lamc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lamc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .step          (step),
    .operation     (in_op_r),
    .move_mm       (in_mm_r),
    .encoder_edges (in_edges_r),
    .res           (res)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.running   = res.running;
  assign out_ch.direction = res.direction;
  assign out_ch.position  = res.position;
  assign out_ch.event_res = res.event_res;

endmodule
`default_nettype wire

@@ hw/rtl/lamc_cfg_regs.sv @@
`default_nettype none
module lamc_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [lamc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [lamc_pkg::CFG_BITS-1:0]       cfg_wdata,
  output lamc_pkg::cfg_t                           cfg
);

  lamc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ppm_q8       <= lamc_pkg::PPM_RESET;
      cfg_r.travel_limit <= lamc_pkg::TRAVEL_RESET;
      cfg_r.stall_win    <= lamc_pkg::STALL_WIN_RESET;
      cfg_r.home_win     <= lamc_pkg::HOME_WIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lamc_pkg::CFG_PPM:       cfg_r.ppm_q8       <= cfg_wdata[lamc_pkg::PPM_BITS-1:0];
        lamc_pkg::CFG_TRAVEL:    cfg_r.travel_limit <= cfg_wdata[19:0];
        lamc_pkg::CFG_STALL_WIN: cfg_r.stall_win    <= cfg_wdata[lamc_pkg::WIN_BITS-1:0];
        lamc_pkg::CFG_HOME_WIN:  cfg_r.home_win     <= cfg_wdata[lamc_pkg::WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ hw/rtl/lamc_target.sv @@
`default_nettype none
module lamc_target (
  input  wire lamc_pkg::cfg_t                        cfg,
  input  wire logic signed [lamc_pkg::MM_BITS-1:0]   move_mm,
  input  wire lamc_pkg::pos_t                        cur_position,
  output lamc_pkg::cmd_t                             cmd
);

  logic [lamc_pkg::MM_BITS-1:0]   mm_raw;
  logic [lamc_pkg::MM_BITS-1:0]   mag;
  logic [lamc_pkg::PROD_BITS-1:0] prod;
  logic [lamc_pkg::RAW_BITS-1:0]  raw_tgt;
  logic [lamc_pkg::RAW_BITS:0]    reach;
  logic                           push;

  always_comb begin
    mm_raw  = move_mm;
    // magnitude of the most negative length still fits as unsigned
    mag     = mm_raw[lamc_pkg::MM_BITS-1] ? (~mm_raw + 1'b1) : mm_raw;
    prod    = lamc_pkg::PROD_BITS'(cfg.ppm_q8) * lamc_pkg::PROD_BITS'(mag);
    raw_tgt = {prod[lamc_pkg::PROD_BITS-1:8], 2'b00};
    reach   = (lamc_pkg::RAW_BITS+1)'(raw_tgt) + (lamc_pkg::RAW_BITS+1)'(cur_position);
    push    = !mm_raw[lamc_pkg::MM_BITS-1] && (mm_raw != '0);

    cmd.dir = push ? lamc_pkg::DIR_OUTWARD : lamc_pkg::DIR_RETRACT;
    if (push) begin
      if (reach < (lamc_pkg::RAW_BITS+1)'(cfg.travel_limit)) begin
        cmd.target = raw_tgt[lamc_pkg::POS_BITS-1:0];
      end else if (cur_position < cfg.travel_limit) begin
        cmd.target = cfg.travel_limit - cur_position;
      end else begin
        cmd.target = '0;
      end
    end else begin
      // clamp retract to what is left above the minimum
      if (raw_tgt > lamc_pkg::RAW_BITS'(cur_position)) begin
        cmd.target = cur_position;
      end else begin
        cmd.target = raw_tgt[lamc_pkg::POS_BITS-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/lamc_core.sv @@
`default_nettype none
module lamc_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire lamc_pkg::cfg_t                        cfg,
  input  wire logic                                  step,
  input  wire logic [lamc_pkg::OP_BITS-1:0]          operation,
  input  wire logic signed [lamc_pkg::MM_BITS-1:0]   move_mm,
  input  wire logic [lamc_pkg::EDGE_BITS-1:0]        encoder_edges,
  output lamc_pkg::res_t                             res
);

  logic           motor_on_r, motor_on_nxt;
  logic           move_dir_r, move_dir_nxt;
  logic           homing_r, homing_nxt;
  lamc_pkg::pos_t position_r, position_nxt;
  lamc_pkg::pos_t target_r, target_nxt;
  lamc_pkg::pos_t moved_r, moved_nxt;
  lamc_pkg::win_t win_cnt_r, win_cnt_nxt;
  logic           moved_in_win_r, moved_in_win_nxt;
  lamc_pkg::res_t res_r;
  logic [lamc_pkg::EV_BITS-1:0] ev;

  lamc_pkg::cmd_t                cmd;
  logic [lamc_pkg::POS_BITS:0]   moved_sum;
  lamc_pkg::pos_t                moved_sat;
  logic [lamc_pkg::POS_BITS:0]   pos_sum;
  lamc_pkg::pos_t                pos_done;
  lamc_pkg::win_t                win_inc;
  lamc_pkg::win_t                window;
  logic                          miw_inc;

  lamc_target u_target (
    .cfg          (cfg),
    .move_mm      (move_mm),
    .cur_position (position_r),
    .cmd          (cmd)
  );

  always_comb begin
    moved_sum = (lamc_pkg::POS_BITS+1)'(moved_r) + (lamc_pkg::POS_BITS+1)'(encoder_edges);
    moved_sat = moved_sum[lamc_pkg::POS_BITS] ? '1 : moved_sum[lamc_pkg::POS_BITS-1:0];
    // position after a move ends with moved_sat edges travelled
    pos_sum   = (lamc_pkg::POS_BITS+1)'(position_r) + (lamc_pkg::POS_BITS+1)'(moved_sat);
    if (move_dir_r == lamc_pkg::DIR_OUTWARD) begin
      pos_done = pos_sum[lamc_pkg::POS_BITS] ? '1 : pos_sum[lamc_pkg::POS_BITS-1:0];
    end else begin
      pos_done = (moved_sat > position_r) ? '0 : position_r - moved_sat;
    end
    win_inc = win_cnt_r + 1'b1;
    window  = homing_r ? cfg.home_win : cfg.stall_win;
    miw_inc = moved_in_win_r || (encoder_edges != '0);

    motor_on_nxt     = motor_on_r;
    move_dir_nxt     = move_dir_r;
    homing_nxt       = homing_r;
    position_nxt     = position_r;
    target_nxt       = target_r;
    moved_nxt        = moved_r;
    win_cnt_nxt      = win_cnt_r;
    moved_in_win_nxt = moved_in_win_r;
    ev               = lamc_pkg::EV_NONE;

    case (operation)
      lamc_pkg::OP_TICK: begin
        if (motor_on_r) begin
          moved_nxt = moved_sat;
          if (!homing_r && moved_sat >= target_r) begin
            motor_on_nxt = 1'b0;
            position_nxt = pos_done;
            ev           = lamc_pkg::EV_REACHED;
          end else if (win_inc >= window || win_inc == '0) begin
            if (!miw_inc) begin
              motor_on_nxt = 1'b0;
              win_cnt_nxt  = win_inc;
              if (homing_r) begin
                homing_nxt   = 1'b0;
                position_nxt = '0;
                ev           = lamc_pkg::EV_HOMED;
              end else begin
                position_nxt = pos_done;
                ev           = lamc_pkg::EV_STALLED;
              end
            end else begin
              // window closed with motion: open the next one
              win_cnt_nxt      = '0;
              moved_in_win_nxt = 1'b0;
            end
          end else begin
            win_cnt_nxt      = win_inc;
            moved_in_win_nxt = miw_inc;
          end
        end
      end
      lamc_pkg::OP_MOVE: begin
        if (motor_on_r) begin
          ev = lamc_pkg::EV_BUSY;
        end else begin
          move_dir_nxt = cmd.dir;
          target_nxt   = cmd.target;
          if (cmd.target == '0) begin
            ev = lamc_pkg::EV_REACHED;
          end else begin
            homing_nxt       = 1'b0;
            motor_on_nxt     = 1'b1;
            moved_nxt        = '0;
            win_cnt_nxt      = '0;
            moved_in_win_nxt = 1'b0;
          end
        end
      end
      lamc_pkg::OP_HOME: begin
        if (motor_on_r) begin
          ev = lamc_pkg::EV_BUSY;
        end else begin
          homing_nxt       = 1'b1;
          motor_on_nxt     = 1'b1;
          move_dir_nxt     = lamc_pkg::DIR_RETRACT;
          moved_nxt        = '0;
          win_cnt_nxt      = '0;
          moved_in_win_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_on_r     <= 1'b0;
      move_dir_r     <= lamc_pkg::DIR_OUTWARD;
      homing_r       <= 1'b0;
      position_r     <= '0;
      target_r       <= '0;
      moved_r        <= '0;
      win_cnt_r      <= '0;
      moved_in_win_r <= 1'b0;
    end else if (step) begin
      motor_on_r     <= motor_on_nxt;
      move_dir_r     <= move_dir_nxt;
      homing_r       <= homing_nxt;
      position_r     <= position_nxt;
      target_r       <= target_nxt;
      moved_r        <= moved_nxt;
      win_cnt_r      <= win_cnt_nxt;
      moved_in_win_r <= moved_in_win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r.running   <= motor_on_nxt;
      res_r.direction <= move_dir_nxt;
      res_r.position  <= 20'(position_nxt);
      res_r.event_res <= ev;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

@@ tb/lamc_result_check.sv @@
`timescale 1ns / 100ps
module lamc_result_check
  import lamc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  lamc_in_if                      in_ch,
  lamc_out_if                     out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_wdata,
  output int unsigned             fail_count,
  output int unsigned             pending_results,
  output logic                    motor_busy
);

  // register copies
  logic [PPM_BITS-1:0] ppm_cfg;
  logic [19:0]         limit_cfg;
  win_t                stall_cfg;
  win_t                home_cfg;

  // actuator state
  logic run_q;
  logic dir_q;
  logic homing_q;
  logic saw_edge_q;
  pos_t pos_q;
  pos_t goal_q;
  pos_t travelled_q;
  win_t window_ticks_q;

  res_t status_q[$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic void launch_motor(input logic dir);
    run_q          = 1'b1;
    dir_q          = dir;
    travelled_q    = '0;
    window_ticks_q = '0;
    saw_edge_q     = 1'b0;
  endfunction

  // Stop and book the edges actually travelled; clamp at both ends.
  function automatic void settle_position();
    logic [POS_BITS:0] sum;
    run_q = 1'b0;
    if (dir_q == DIR_OUTWARD) begin
      sum   = {1'b0, pos_q} + {1'b0, travelled_q};
      pos_q = sum[POS_BITS] ? '1 : sum[POS_BITS-1:0];
    end else begin
      pos_q = (travelled_q > pos_q) ? '0 : pos_q - travelled_q;
    end
  endfunction

  function automatic logic [EV_BITS-1:0] command_move(input logic signed [MM_BITS-1:0] mm);
    int          mm_i;
    int unsigned mag;
    logic [63:0] span;
    logic        dir;
    mm_i = mm;
    mag  = (mm_i < 0) ? -mm_i : mm_i;
    span = ((64'(ppm_cfg) * 64'(mag)) >> 8) << 2;
    dir  = (mm > 0) ? DIR_OUTWARD : DIR_RETRACT;
    if (dir == DIR_OUTWARD) begin
      if (span + 64'(pos_q) >= 64'(limit_cfg))
        span = (pos_q < limit_cfg) ? 64'(limit_cfg - pos_q) : 64'd0;
    end else if (span > 64'(pos_q)) begin
      span = 64'(pos_q);
    end
    dir_q  = dir;
    goal_q = span[POS_BITS-1:0];
    if (goal_q == '0) return EV_REACHED;
    homing_q = 1'b0;
    launch_motor(dir);
    return EV_NONE;
  endfunction

  function automatic logic [EV_BITS-1:0] advance_tick(input logic [EDGE_BITS-1:0] edges);
    logic [POS_BITS:0] sum;
    win_t              span_ticks;
    if (!run_q) return EV_NONE;
    sum         = {1'b0, travelled_q} + (POS_BITS + 1)'(edges);
    travelled_q = sum[POS_BITS] ? '1 : sum[POS_BITS-1:0];
    // homing ignores the goal and ends on its window only
    if (!homing_q && travelled_q >= goal_q) begin
      settle_position();
      return EV_REACHED;
    end
    if (edges != '0) saw_edge_q = 1'b1;
    window_ticks_q = window_ticks_q + 1'b1;
    span_ticks     = homing_q ? home_cfg : stall_cfg;
    if (window_ticks_q >= span_ticks || window_ticks_q == '0) begin
      if (!saw_edge_q) begin
        if (homing_q) begin
          run_q    = 1'b0;
          homing_q = 1'b0;
          pos_q    = '0;
          return EV_HOMED;
        end
        settle_position();
        return EV_STALLED;
      end
      window_ticks_q = '0;
      saw_edge_q     = 1'b0;
    end
    return EV_NONE;
  endfunction

  function automatic res_t step_actuator(input logic [OP_BITS-1:0] op,
                                         input logic signed [MM_BITS-1:0] mm,
                                         input logic [EDGE_BITS-1:0] edges);
    res_t r;
    logic [EV_BITS-1:0] ev;
    ev = EV_NONE;
    case (op)
      OP_TICK: ev = advance_tick(edges);
      OP_MOVE, OP_HOME: begin
        if (run_q) ev = EV_BUSY;
        else if (op == OP_MOVE) ev = command_move(mm);
        else begin
          homing_q = 1'b1;
          launch_motor(DIR_RETRACT);
        end
      end
      default: ;
    endcase
    r.running   = run_q;
    r.direction = dir_q;
    r.position  = pos_q;
    r.event_res = ev;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t seen;
    res_t want;
    if (!rst_n) begin
      ppm_cfg        = PPM_RESET;
      limit_cfg      = TRAVEL_RESET;
      stall_cfg      = STALL_WIN_RESET;
      home_cfg       = HOME_WIN_RESET;
      run_q          = 1'b0;
      dir_q          = DIR_OUTWARD;
      homing_q       = 1'b0;
      saw_edge_q     = 1'b0;
      pos_q          = '0;
      goal_q         = '0;
      travelled_q    = '0;
      window_ticks_q = '0;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PPM:       ppm_cfg   = cfg_wdata[PPM_BITS-1:0];
          CFG_TRAVEL:    limit_cfg = cfg_wdata[19:0];
          CFG_STALL_WIN: stall_cfg = cfg_wdata[WIN_BITS-1:0];
          CFG_HOME_WIN:  home_cfg  = cfg_wdata[WIN_BITS-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        status_q.push_back(step_actuator(in_ch.operation, in_ch.move_mm, in_ch.encoder_edges));
      if (out_ch.valid && out_ch.ready) begin
        seen.running   = out_ch.running;
        seen.direction = out_ch.direction;
        seen.position  = out_ch.position;
        seen.event_res = out_ch.event_res;
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, position %0d event %0d",
                                    seen.position, seen.event_res));
        end else begin
          want = status_q.pop_front();
          if (seen.running !== want.running)
            report_mismatch($sformatf("running %0d, expected %0d",
                                      seen.running, want.running));
          if (seen.direction !== want.direction)
            report_mismatch($sformatf("direction %0d, expected %0d",
                                      seen.direction, want.direction));
          if (seen.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      seen.position, want.position));
          if (seen.event_res !== want.event_res)
            report_mismatch($sformatf("event %0d, expected %0d",
                                      seen.event_res, want.event_res));
        end
      end
    end
    pending_results = status_q.size();
    motor_busy      = run_q;
  end

endmodule

@@ tb/tb_linear_actuator_move_controller.sv @@
`timescale 1ns / 100ps
module tb_linear_actuator_move_controller;
  import lamc_pkg::*;

  localparam logic [OP_BITS-1:0]       OP_SPARE = 2'd3;
  localparam logic signed [MM_BITS-1:0] MM_MIN  = 13'h1000;
  localparam logic signed [MM_BITS-1:0] MM_MAX  = 13'h0FFF;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_wdata;

  int unsigned fail_count;
  int unsigned pending_results;
  logic        motor_busy;
  logic        running_now;

  int burst_left = 0;
  int items_done = 0;
  int ready_mode = 0;
  int ready_hold = 0;
  int ready_phase = 0;

  lamc_in_if  in_ch ();
  lamc_out_if out_ch ();

  linear_actuator_move_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lamc_result_check result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .motor_busy      (motor_busy)
  );

  always #5 clk = ~clk;

  // Result side: switch between four ready patterns at random.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (ready_hold == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_hold = $urandom_range(16, 96);
      end else begin
        ready_hold--;
      end
      ready_phase++;
      case (ready_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ((ready_phase % 5) < 3);
      endcase
    end
  end

  task automatic send_item(input logic [OP_BITS-1:0] op,
                           input logic signed [MM_BITS-1:0] mm,
                           input logic [EDGE_BITS-1:0] edges);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.move_mm       <= mm;
    in_ch.encoder_edges <= edges;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_done++;
  endtask

  // Hold the input idle until every transaction has its result.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    running_now = motor_busy;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [PPM_BITS-1:0] ppm, input logic [19:0] travel,
                             input win_t stall, input win_t home);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PPM;
    cfg_wdata <= CFG_BITS'(ppm);
    @(posedge clk);
    cfg_index <= CFG_TRAVEL;
    cfg_wdata <= CFG_BITS'(travel);
    @(posedge clk);
    cfg_index <= CFG_STALL_WIN;
    cfg_wdata <= CFG_BITS'(stall);
    @(posedge clk);
    cfg_index <= CFG_HOME_WIN;
    cfg_wdata <= CFG_BITS'(home);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Feed encoder ticks in bursts until the motor is off; go quiet after a while
  // so the stall or home window ends the run.
  task automatic run_until_stopped(input int quiet_pct);
    int ticks;
    logic [EDGE_BITS-1:0] e;
    ticks = 0;
    forever begin
      repeat ($urandom_range(1, 8)) begin
        if (ticks >= 48 || $urandom_range(0, 99) < quiet_pct) e = '0;
        else e = EDGE_BITS'($urandom_range(1, 15));
        if ($urandom_range(0, 39) == 0)
          send_item($urandom_range(0, 1) ? OP_MOVE : OP_HOME, MM_BITS'($urandom()), e);
        send_item(OP_TICK, MM_BITS'($urandom()), e);
        ticks++;
      end
      wait_drained();
      if (!running_now) break;
    end
  endtask

  task automatic run_random_phase(input int budget, input int max_mm);
    int first;
    int mark;
    int pick;
    int mag;
    logic signed [MM_BITS-1:0] mm;
    first = items_done;
    while (items_done - first < budget) begin
      pick = $urandom_range(0, 99);
      mag  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, max_mm);
      if ($urandom_range(0, 1) == 1) begin
        mm = MM_BITS'(-mag);
      end else begin
        if (mag > 4095) mag = 4095;
        mm = MM_BITS'(mag);
      end
      if (pick < 50) begin
        send_item(OP_MOVE, mm, EDGE_BITS'($urandom()));
        run_until_stopped(8);
      end else if (pick < 65) begin
        send_item(OP_HOME, mm, EDGE_BITS'($urandom()));
        run_until_stopped(15);
      end else if (pick < 80) begin
        send_item(OP_MOVE, mm, EDGE_BITS'($urandom()));
        run_until_stopped(90);
      end else begin
        // noise does not count toward the budget
        mark = items_done;
        repeat ($urandom_range(1, 4))
          send_item(OP_BITS'($urandom()), MM_BITS'($urandom()), EDGE_BITS'($urandom()));
        items_done = mark;
      end
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_TICK;
    in_ch.move_mm       <= '0;
    in_ch.encoder_edges <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_PPM;
    cfg_wdata           <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: idle tick, spare opcode, zero targets, busy commands,
    // overshoot at both ends, both clamps, then a stall
    send_item(OP_TICK, '0, 4'd15);
    send_item(OP_SPARE, MM_MIN, 4'd15);
    send_item(OP_MOVE, '0, '0);
    send_item(OP_MOVE, -13'sd1, '0);
    send_item(OP_MOVE, 13'sd1, '0);
    send_item(OP_MOVE, MM_MAX, 4'd15);
    send_item(OP_HOME, MM_MIN, 4'd15);
    send_item(OP_SPARE, '0, '0);
    repeat (6) send_item(OP_TICK, '0, 4'd15);
    send_item(OP_MOVE, MM_MIN, '0);
    repeat (7) send_item(OP_TICK, '0, 4'd14);
    send_item(OP_MOVE, MM_MAX, '0);
    send_item(OP_TICK, '0, 4'd8);
    run_until_stopped(100);

    load_config(16'd1, 20'hFFFFF, 10'd1, 10'd1);
    run_random_phase(60, 4095);

    run_until_stopped(100);
    load_config(16'hFFFF, 20'd0, 10'd2, 10'd3);
    run_random_phase(40, 2);

    // zero-length windows act as one tick
    run_until_stopped(100);
    load_config(16'd256, 20'd300, 10'd0, 10'd0);
    run_random_phase(60, 40);

    // full travel: home, push to the limit and overshoot past it
    run_until_stopped(100);
    load_config(16'hFFFF, 20'd600, 10'd12, 10'd1);
    send_item(OP_HOME, '0, '0);
    send_item(OP_TICK, '0, '0);
    send_item(OP_MOVE, MM_MAX, '0);
    send_item(OP_TICK, '0, 4'd7);
    repeat (40) send_item(OP_TICK, '0, 4'd15);
    send_item(OP_MOVE, 13'sd3, '0);
    send_item(OP_MOVE, -13'sd1, '0);
    send_item(OP_TICK, '0, 4'd5);
    run_until_stopped(100);
    send_item(OP_HOME, '0, '0);
    send_item(OP_TICK, '0, '0);
    wait_drained();

    repeat (3) begin
      run_until_stopped(100);
      load_config(PPM_BITS'($urandom_range(64, 1500)), 20'($urandom_range(50, 3000)),
                  WIN_BITS'($urandom_range(1, 6)), WIN_BITS'($urandom_range(1, 9)));
      run_random_phase(40, 8);
    end

    // home window that closes once with motion before homing ends
    run_until_stopped(100);
    load_config(PPM_RESET, TRAVEL_RESET, 10'd5, 10'd20);
    send_item(OP_HOME, '0, '0);
    send_item(OP_TICK, '0, 4'd9);
    run_until_stopped(100);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/lamc_pkg.sv
hw/rtl/lamc_in_if.sv
hw/rtl/lamc_out_if.sv
hw/rtl/lamc_cfg_regs.sv
hw/rtl/lamc_target.sv
hw/rtl/lamc_core.sv
hw/rtl/linear_actuator_move_controller.sv
tb/lamc_result_check.sv
tb/tb_linear_actuator_move_controller.sv
